/* sv/ads_pkg.sv */
// ----------------------------------------------------------------------------
// ads_pkg: shared types and constants for the advection-diffusion step
// Widths, register codes, command and line-entry layouts, back-end states.
// ----------------------------------------------------------------------------
package ads_pkg;

  // grid and sample geometry
  localparam int MAX_GRID   = 256;
  localparam int MIN_GRID   = 3;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_GRID);
  localparam int CNT_W      = $clog2(MAX_GRID + 1);

  // register and field widths fixed by the formats
  localparam int SIZE_W     = 9;
  localparam int AGAIN_W    = 24;
  localparam int DGAIN_W    = 16;
  localparam int VEL_W      = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADV_GAIN_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADV_GAIN_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_GAIN_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_GAIN_Y = 3'd4;

  localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 9'd256;

  // input item codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_DRAIN  = 1'b1;

  // datapath widths; the sum is exact at scale 2^-(32+14)
  localparam int ACC_FRAC   = 32;
  localparam int DIFF_SHIFT = 16;
  localparam int DC_W       = VALUE_BITS + 1;
  localparam int LAP_W      = VALUE_BITS + 3;
  localparam int MX_W       = VEL_W + DC_W;
  localparam int DX_W       = DGAIN_W + 1 + LAP_W;
  localparam int P_W        = AGAIN_W + 1 + MX_W;
  localparam int ACC_W      = AGAIN_W + VEL_W + VALUE_BITS + 3;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  typedef enum logic [0:0] {
    CMD_SAMPLE,
    CMD_DRAIN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic                    emit;      // sample that releases a result
    logic                    boundary;  // released cell is on the grid edge
    logic                    last;      // drained cell closes the frame
    logic                    use_mid;   // drained cell lies in the last row
    logic [IDX_W-1:0]        col;
    logic [VALUE_BITS-1:0]   conc;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
  } cmd_t;

  // one column of the line store
  typedef struct packed {
    logic [VEL_W-1:0]      vel_y;
    logic [VEL_W-1:0]      vel_x;
    logic [VALUE_BITS-1:0] up;
    logic [VALUE_BITS-1:0] mid;
  } entry_t;

  typedef struct packed {
    logic [AGAIN_W-1:0] adv_x;
    logic [AGAIN_W-1:0] adv_y;
    logic [DGAIN_W-1:0] diff_x;
    logic [DGAIN_W-1:0] diff_y;
  } gains_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ACCESS,
    BK_MUL1,
    BK_MUL2,
    BK_SUM,
    BK_FIN
  } bk_state_t;

endpackage

/* sv/ads_ram.sv */
// ----------------------------------------------------------------------------
// ads_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ads_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/ads_front.sv */
// ----------------------------------------------------------------------------
// ads_front: input side of the stencil step
// Tracks sample and result positions, classifies each beat, builds commands.
// ----------------------------------------------------------------------------
module ads_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [ads_pkg::CNT_W-1:0]     grid_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          func,
  input  logic [ads_pkg::VALUE_BITS-1:0] concentration,
  input  logic signed [ads_pkg::VEL_W-1:0] vel_x,
  input  logic signed [ads_pkg::VEL_W-1:0] vel_y,
  input  logic                          q_full,
  output logic                          q_push,
  output ads_pkg::cmd_t                 q_cmd
);

  logic [ads_pkg::CNT_W-1:0] in_row;
  logic [ads_pkg::IDX_W-1:0] in_col;
  logic [ads_pkg::IDX_W-1:0] out_row;
  logic [ads_pkg::IDX_W-1:0] out_col;

  logic                      accept;
  logic                      is_sample;
  logic                      is_drain;
  logic                      emit;
  logic                      boundary;
  logic                      in_col_wrap;
  logic                      out_col_wrap;
  logic                      last_row;
  logic                      last_cell;
  logic [ads_pkg::CNT_W-1:0] n_minus1;

  assign full     = q_full;
  assign accept   = push && !q_full;
  assign n_minus1 = grid_n - ads_pkg::CNT_W'(1);

  // a sample past the frame's last row behaves as a drain
  assign is_sample = (func == ads_pkg::FUNC_SAMPLE) && (in_row < grid_n);
  assign is_drain  = !is_sample && (in_row >= grid_n);

  // result lags one row plus one cell
  assign emit = (in_row >= ads_pkg::CNT_W'(2)) ||
                ((in_row == ads_pkg::CNT_W'(1)) && (in_col != '0));

  assign last_row  = (ads_pkg::CNT_W'(out_row) == n_minus1);
  assign last_cell = last_row && (ads_pkg::CNT_W'(out_col) == n_minus1);
  assign boundary  = (out_row == '0) || last_row || (out_col == '0) ||
                     (ads_pkg::CNT_W'(out_col) == n_minus1);

  assign in_col_wrap  = (ads_pkg::CNT_W'(in_col) == n_minus1);
  assign out_col_wrap = (ads_pkg::CNT_W'(out_col) == n_minus1);

  always_comb begin
    q_push         = accept && (is_sample || is_drain);
    q_cmd.kind     = is_sample ? ads_pkg::CMD_SAMPLE : ads_pkg::CMD_DRAIN;
    q_cmd.emit     = is_sample ? emit : 1'b1;
    q_cmd.boundary = boundary;
    q_cmd.last     = last_cell;
    q_cmd.use_mid  = last_row;
    q_cmd.col      = is_sample ? in_col : out_col;
    q_cmd.conc     = concentration;
    q_cmd.vel_x    = vel_x;
    q_cmd.vel_y    = vel_y;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (accept) begin
      if (is_sample) begin
        if (in_col_wrap) begin
          in_col <= '0;
          in_row <= in_row + ads_pkg::CNT_W'(1);
        end else begin
          in_col <= in_col + ads_pkg::IDX_W'(1);
        end
      end
      if ((is_sample && emit) || (is_drain && !last_cell)) begin
        if (out_col_wrap) begin
          out_col <= '0;
          out_row <= out_row + ads_pkg::IDX_W'(1);
        end else begin
          out_col <= out_col + ads_pkg::IDX_W'(1);
        end
      end else if (is_drain && last_cell) begin
        // frame closed: start over
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
      end
    end
  end

endmodule

/* sv/ads_cmd_queue.sv */
// ----------------------------------------------------------------------------
// ads_cmd_queue: short command queue between front and back
// Plain circular buffer with occupancy count; head is shown combinationally.
// ----------------------------------------------------------------------------
module ads_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  ads_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd_en,
  output ads_pkg::cmd_t rd_cmd,
  output logic          empty
);

  ads_pkg::cmd_t                 slots [ads_pkg::CMDQ_DEPTH];
  logic [ads_pkg::CMDQ_PTR_W-1:0] wr_ptr;
  logic [ads_pkg::CMDQ_PTR_W-1:0] rd_ptr;
  logic [ads_pkg::CMDQ_PTR_W:0]   count;
  logic                          do_wr;
  logic                          do_rd;

  assign full   = (count == (ads_pkg::CMDQ_PTR_W + 1)'(ads_pkg::CMDQ_DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + ads_pkg::CMDQ_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + ads_pkg::CMDQ_PTR_W'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + (ads_pkg::CMDQ_PTR_W + 1)'(1);
        2'b01:   count <= count - (ads_pkg::CMDQ_PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/ads_back.sv */
// ----------------------------------------------------------------------------
// ads_back: execution side of the stencil step
// Line store access, neighbor window, stencil arithmetic, result register.
// ----------------------------------------------------------------------------
module ads_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ads_pkg::gains_t               gains,
  input  logic                          q_empty,
  input  ads_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [ads_pkg::VALUE_BITS-1:0] new_value,
  output logic                          frame_last,
  output logic                          clipped
);

  localparam int VB = ads_pkg::VALUE_BITS;

  ads_pkg::bk_state_t state, state_next;
  ads_pkg::cmd_t      cur;

  // line store port signals
  logic                      rd_en;
  logic [ads_pkg::IDX_W-1:0] rd_addr;
  ads_pkg::entry_t           rd_entry;
  logic                      wr_en;
  ads_pkg::entry_t           wr_entry;

  // window and one-cell delays
  logic [VB-1:0]                w0, w1, w2;
  logic [VB-1:0]                up_hold;
  logic [VB-1:0]                down_hold;
  logic signed [ads_pkg::VEL_W-1:0] vx_hold, vy_hold;

  // operands of the cell being updated
  logic [VB-1:0]                op_c, op_l, op_r, op_u, op_d;
  logic signed [ads_pkg::VEL_W-1:0] op_vx, op_vy;

  // pipeline of the interior update
  logic signed [ads_pkg::DC_W-1:0]  dcx, dcy;
  logic signed [ads_pkg::LAP_W-1:0] lap_x, lap_y;
  logic signed [ads_pkg::MX_W-1:0]  m_x, m_y;
  logic signed [ads_pkg::DX_W-1:0]  d_x, d_y;
  logic signed [ads_pkg::P_W-1:0]   p_x, p_y;
  logic signed [ads_pkg::DX_W:0]    d_sum;
  logic signed [ads_pkg::ACC_W-1:0] adv, pos, acc;

  // result of the current item
  logic          fin_pass;
  logic          fin_last;
  logic [VB-1:0] pass_val;
  logic          load_out;
  logic [VB-1:0] upd_val;
  logic          upd_clip;
  logic          acc_neg;
  logic          acc_over;
  logic          res_valid;

  ads_ram #(
    .WIDTH ($bits(ads_pkg::entry_t)),
    .DEPTH (ads_pkg::MAX_GRID)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur.col),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  assign empty = !res_valid;

  // line entry after a sample: new value in, old middle moves up
  always_comb begin
    wr_entry.mid   = cur.conc;
    wr_entry.up    = rd_entry.mid;
    wr_entry.vel_x = cur.vel_x;
    wr_entry.vel_y = cur.vel_y;
  end

  // --- state machine ---
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ads_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = q_cmd.col;
    wr_en      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ads_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          rd_en      = 1'b1;
          state_next = ads_pkg::BK_ACCESS;
        end
      end
      ads_pkg::BK_ACCESS: begin
        if (cur.kind == ads_pkg::CMD_SAMPLE) begin
          wr_en = 1'b1;
          if (!cur.emit) begin
            state_next = ads_pkg::BK_IDLE;
          end else if (cur.boundary) begin
            state_next = ads_pkg::BK_FIN;
          end else begin
            state_next = ads_pkg::BK_MUL1;
          end
        end else begin
          state_next = ads_pkg::BK_FIN;
        end
      end
      ads_pkg::BK_MUL1: state_next = ads_pkg::BK_MUL2;
      ads_pkg::BK_MUL2: state_next = ads_pkg::BK_SUM;
      ads_pkg::BK_SUM:  state_next = ads_pkg::BK_FIN;
      ads_pkg::BK_FIN: begin
        if (!res_valid || pop) begin
          load_out   = 1'b1;
          state_next = ads_pkg::BK_IDLE;
        end
      end
      default: state_next = ads_pkg::BK_IDLE;
    endcase
  end

  // --- first multiply stage operands ---
  always_comb begin
    dcx   = (op_vx > 0) ? ($signed({1'b0, op_c}) - $signed({1'b0, op_l}))
                        : ($signed({1'b0, op_r}) - $signed({1'b0, op_c}));
    dcy   = (op_vy > 0) ? ($signed({1'b0, op_c}) - $signed({1'b0, op_u}))
                        : ($signed({1'b0, op_d}) - $signed({1'b0, op_c}));
    lap_x = $signed({3'b000, op_l}) + $signed({3'b000, op_r})
          - $signed({2'b00, op_c, 1'b0});
    lap_y = $signed({3'b000, op_u}) + $signed({3'b000, op_d})
          - $signed({2'b00, op_c, 1'b0});
  end

  // --- final subtract and clamp ---
  always_comb begin
    acc      = pos - adv;
    acc_neg  = acc[ads_pkg::ACC_W-1];
    acc_over = !acc_neg && (|acc[ads_pkg::ACC_W-2:ads_pkg::ACC_FRAC+VB]);
    if (acc_neg) begin
      upd_val = '0;
    end else if (acc_over) begin
      upd_val = '1;
    end else begin
      upd_val = acc[ads_pkg::ACC_FRAC +: VB];
    end
    upd_clip = acc_neg || acc_over;
  end

  // --- datapath registers ---
  always_ff @(posedge clk) begin
    unique case (state)
      ads_pkg::BK_IDLE: begin
        if (!q_empty) begin
          cur <= q_cmd;
        end
      end
      ads_pkg::BK_ACCESS: begin
        if (cur.kind == ads_pkg::CMD_SAMPLE) begin
          w0        <= w1;
          w1        <= w2;
          w2        <= rd_entry.mid;
          up_hold   <= rd_entry.up;
          vx_hold   <= $signed(rd_entry.vel_x);
          vy_hold   <= $signed(rd_entry.vel_y);
          down_hold <= cur.conc;
          // neighborhood of the released cell, window after the shift
          op_l      <= w1;
          op_c      <= w2;
          op_r      <= rd_entry.mid;
          op_u      <= up_hold;
          op_d      <= down_hold;
          op_vx     <= vx_hold;
          op_vy     <= vy_hold;
          pass_val  <= w2;
          fin_pass  <= cur.boundary;
          fin_last  <= 1'b0;
        end else begin
          pass_val  <= cur.use_mid ? rd_entry.mid : rd_entry.up;
          fin_pass  <= 1'b1;
          fin_last  <= cur.last;
        end
      end
      ads_pkg::BK_MUL1: begin
        m_x <= op_vx * dcx;
        m_y <= op_vy * dcy;
        d_x <= $signed({1'b0, gains.diff_x}) * lap_x;
        d_y <= $signed({1'b0, gains.diff_y}) * lap_y;
      end
      ads_pkg::BK_MUL2: begin
        p_x   <= $signed({1'b0, gains.adv_x}) * m_x;
        p_y   <= $signed({1'b0, gains.adv_y}) * m_y;
        d_sum <= (ads_pkg::DX_W + 1)'(d_x) + (ads_pkg::DX_W + 1)'(d_y);
      end
      ads_pkg::BK_SUM: begin
        adv <= ads_pkg::ACC_W'(p_x) + ads_pkg::ACC_W'(p_y);
        // centre at full scale, half-up rounding, diffusion at 2^16
        pos <= (ads_pkg::ACC_W'(op_c) << ads_pkg::ACC_FRAC)
             + (ads_pkg::ACC_W'(1) << (ads_pkg::ACC_FRAC - 1))
             + (ads_pkg::ACC_W'(d_sum) << ads_pkg::DIFF_SHIFT);
      end
      default: begin
      end
    endcase
  end

  // --- result register ---
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      new_value  <= fin_pass ? pass_val : upd_val;
      clipped    <= fin_pass ? 1'b0 : upd_clip;
      frame_last <= fin_last;
    end
  end

endmodule

/* sv/advection_diffusion_stencil_step_top.sv */
// ----------------------------------------------------------------------------
// advection_diffusion_stencil_step_top: one explicit 2D advection-diffusion step
// Raster-order cell stream in, updated cells out with a one-row-plus-one-cell
// lag; upwind advection, central diffusion, clamp and saturate on the result.
//
//   channel  | handshake                 | beat
//   ---------+---------------------------+-----------------------------------
//   config   | cfg_wr_en                 | cfg_index, cfg_data
//   input    | push / full               | func, concentration, vel_x, vel_y
//   result   | empty / pop               | new_value, frame_last, clipped
//
// Steps: the back end reads the line store, writes a sample back (a sample
// that releases no cell ends there), then an interior cell passes two
// multiply stages and an add stage, and every released cell the final clamp.
// The front end takes a beat every cycle while the 4-entry command queue has
// room; a finished result waits in the output register while work goes on.
// Reset (rst, synchronous) clears counters, queue, back-end state and the
// result valid; the line store is not cleared, since a frame reads only
// columns it has already written.
// ----------------------------------------------------------------------------
module advection_diffusion_stencil_step_top (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic [ads_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ads_pkg::CFG_DATA_W-1:0]     cfg_data,
  // cell stream in
  input  logic                               push,
  output logic                               full,
  input  logic                               func,
  input  logic [ads_pkg::VALUE_BITS-1:0]     concentration,
  input  logic signed [ads_pkg::VEL_W-1:0]   vel_x,
  input  logic signed [ads_pkg::VEL_W-1:0]   vel_y,
  // results out
  input  logic                               pop,
  output logic                               empty,
  output logic [ads_pkg::VALUE_BITS-1:0]     new_value,
  output logic                               frame_last,
  output logic                               clipped
);

  // configuration registers
  logic [ads_pkg::SIZE_W-1:0] grid_size;
  ads_pkg::gains_t            gains;
  logic                       restart;

  // effective grid size, saturated into the supported range
  logic [ads_pkg::CNT_W-1:0]  grid_n;

  // front to queue to back
  logic          fq_push;
  ads_pkg::cmd_t fq_cmd;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  ads_pkg::cmd_t q_head;

  // a grid_size write restarts the frame counters
  assign restart = cfg_wr_en && (cfg_index == ads_pkg::REG_GRID_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size    <= ads_pkg::GRID_SIZE_RESET;
      gains.adv_x  <= '0;
      gains.adv_y  <= '0;
      gains.diff_x <= '0;
      gains.diff_y <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ads_pkg::REG_GRID_SIZE:   grid_size    <= cfg_data[ads_pkg::SIZE_W-1:0];
        ads_pkg::REG_ADV_GAIN_X:  gains.adv_x  <= cfg_data[ads_pkg::AGAIN_W-1:0];
        ads_pkg::REG_ADV_GAIN_Y:  gains.adv_y  <= cfg_data[ads_pkg::AGAIN_W-1:0];
        ads_pkg::REG_DIFF_GAIN_X: gains.diff_x <= cfg_data[ads_pkg::DGAIN_W-1:0];
        ads_pkg::REG_DIFF_GAIN_Y: gains.diff_y <= cfg_data[ads_pkg::DGAIN_W-1:0];
        default: begin
          // unused index: write is dropped
        end
      endcase
    end
  end

  always_comb begin
    if (32'(grid_size) < ads_pkg::MIN_GRID) begin
      grid_n = ads_pkg::CNT_W'(ads_pkg::MIN_GRID);
    end else if (32'(grid_size) > ads_pkg::MAX_GRID) begin
      grid_n = ads_pkg::CNT_W'(ads_pkg::MAX_GRID);
    end else begin
      grid_n = ads_pkg::CNT_W'(grid_size);
    end
  end

  // front: positions and classification of each beat
  ads_front u_front (
    .clk           (clk),
    .rst           (rst),
    .restart       (restart),
    .grid_n        (grid_n),
    .push          (push),
    .full          (full),
    .func          (func),
    .concentration (concentration),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .q_full        (q_full),
    .q_push        (fq_push),
    .q_cmd         (fq_cmd)
  );

  // decoupling queue
  ads_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (fq_push),
    .wr_cmd (fq_cmd),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_cmd (q_head),
    .empty  (q_empty)
  );

  // back: line store, window, arithmetic, result register
  ads_back u_back (
    .clk        (clk),
    .rst        (rst),
    .gains      (gains),
    .q_empty    (q_empty),
    .q_cmd      (q_head),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .new_value  (new_value),
    .frame_last (frame_last),
    .clipped    (clipped)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the advection-diffusion stencil step
// Streams raster-order grid frames (plus drain and stray beats) into the
// block, predicts every updated cell with an in-bench stencil model and
// checks each result beat field by field, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  // ---- bench knobs --------------------------------------------------------
  localparam int ITEM_TARGET    = 1800;  // random beats to queue
  localparam int SETTLE_CYCLES  = 40;    // lets a full command queue drain through the back end
  localparam int LONG_HOLD      = 500;   // one long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on any port
  localparam int BIG_SAMPLES    = 300;   // partial frame on a large grid

  // index with no register behind it; a write must change nothing
  localparam logic [ads_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // one input beat and one result beat
  typedef struct packed {
    logic                           func;
    logic [ads_pkg::VALUE_BITS-1:0] conc;
    logic [ads_pkg::VEL_W-1:0]      vx;
    logic [ads_pkg::VEL_W-1:0]      vy;
  } cell_beat_t;

  typedef struct packed {
    logic [ads_pkg::VALUE_BITS-1:0] value;
    logic                           last;
    logic                           clip;
  } cell_result_t;

  // ---- DUT ports, all known from time zero ---------------------------------
  logic                                  clk           = 1'b0;
  logic                                  rst           = 1'b1;
  logic                                  cfg_wr_en     = 1'b0;
  logic [ads_pkg::CFG_IDX_W-1:0]         cfg_index     = ads_pkg::REG_GRID_SIZE;
  logic [ads_pkg::CFG_DATA_W-1:0]        cfg_data      = '0;
  logic                                  push          = 1'b0;
  logic                                  full;
  logic                                  func          = ads_pkg::FUNC_SAMPLE;
  logic [ads_pkg::VALUE_BITS-1:0]        concentration = '0;
  logic signed [ads_pkg::VEL_W-1:0]      vel_x         = '0;
  logic signed [ads_pkg::VEL_W-1:0]      vel_y         = '0;
  logic                                  pop           = 1'b0;
  logic                                  empty;
  logic [ads_pkg::VALUE_BITS-1:0]        new_value;
  logic                                  frame_last;
  logic                                  clipped;

  advection_diffusion_stencil_step_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .func          (func),
    .concentration (concentration),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .pop           (pop),
    .empty         (empty),
    .new_value     (new_value),
    .frame_last    (frame_last),
    .clipped       (clipped)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---- bench-side queues and counters --------------------------------------
  cell_beat_t   cell_stream_q[$];   // beats waiting for the driver
  cell_result_t owed_cells_q[$];    // cells the block still owes us
  int unsigned  err_count = 0;
  int unsigned  queued    = 0;

  // ---- stencil model state -------------------------------------------------
  logic [ads_pkg::SIZE_W-1:0]     cfg_size = ads_pkg::GRID_SIZE_RESET;
  logic [ads_pkg::AGAIN_W-1:0]    gain_ax  = '0;
  logic [ads_pkg::AGAIN_W-1:0]    gain_ay  = '0;
  logic [ads_pkg::DGAIN_W-1:0]    gain_dx  = '0;
  logic [ads_pkg::DGAIN_W-1:0]    gain_dy  = '0;
  // two most recent rows per column plus the velocity pair of the newest one;
  // stale entries never reach a checked value, so zero start is harmless
  logic [ads_pkg::VALUE_BITS-1:0] top_line [ads_pkg::MAX_GRID] = '{default: '0};
  logic [ads_pkg::VALUE_BITS-1:0] mid_line [ads_pkg::MAX_GRID] = '{default: '0};
  logic [31:0]                    vel_line [ads_pkg::MAX_GRID] = '{default: '0};
  logic [ads_pkg::VALUE_BITS-1:0] win [3] = '{default: '0};  // left, centre, right
  logic [ads_pkg::VALUE_BITS-1:0] up_dly  = '0;
  logic [31:0]                    vel_dly = '0;
  int unsigned                    row_in  = 0;
  int unsigned                    col_in  = 0;
  int unsigned                    emitted = 0;

  function automatic int unsigned grid_n();
    if (cfg_size < ads_pkg::MIN_GRID) return ads_pkg::MIN_GRID;
    if (cfg_size > ads_pkg::MAX_GRID) return ads_pkg::MAX_GRID;
    return 32'(cfg_size);
  endfunction

  // Interior update, exact at scale 2^-46, rounded half up to Q2.14.
  function automatic void interior_update(
    input  logic [ads_pkg::VALUE_BITS-1:0] cc, ll, rr, uu, dd,
    input  logic [31:0]                    vel,
    output logic [ads_pkg::VALUE_BITS-1:0] val,
    output logic                           clip
  );
    longint vx, vy, c, l, r, u, d, dcx, dcy, acc;
    vx  = longint'($signed(vel[15:0]));
    vy  = longint'($signed(vel[31:16]));
    c   = longint'(cc);
    l   = longint'(ll);
    r   = longint'(rr);
    u   = longint'(uu);
    d   = longint'(dd);
    // upwind: positive velocity looks back (left / up)
    dcx = (vx > 0) ? (c - l) : (r - c);
    dcy = (vy > 0) ? (c - u) : (d - c);
    acc = c << 32;
    acc -= longint'(gain_ax) * vx * dcx;
    acc -= longint'(gain_ay) * vy * dcy;
    acc += (longint'(gain_dx) * (l + r - 2 * c)) * 65536;
    acc += (longint'(gain_dy) * (u + d - 2 * c)) * 65536;
    acc += longint'(1) << 31;
    if (acc < 0) begin
      val  = '0;
      clip = 1'b1;
    end else if ((acc >> 32) > 65535) begin
      val  = '1;
      clip = 1'b1;
    end else begin
      val  = acc[47:32];
      clip = 1'b0;
    end
  endfunction

  // Advance the model by one accepted beat; queue the cell it releases.
  function automatic void predict_stencil_step(input cell_beat_t b);
    int unsigned                    n, total, c, k, pc, e;
    logic [ads_pkg::VALUE_BITS-1:0] down_v, old_up, old_mid, up_v;
    logic [31:0]                    old_vel, vel_v;
    cell_result_t                   res;
    n     = grid_n();
    total = n * n;
    res   = '0;
    if (b.func == ads_pkg::FUNC_SAMPLE && row_in < n) begin
      c       = col_in;
      k       = row_in * n + c;
      pc      = (c == 0) ? n - 1 : c - 1;
      down_v  = mid_line[pc];
      old_up  = top_line[c];
      old_mid = mid_line[c];
      old_vel = vel_line[c];
      up_v    = up_dly;
      vel_v   = vel_dly;
      win[0]  = win[1];
      win[1]  = win[2];
      win[2]  = old_mid;
      up_dly  = old_up;
      vel_dly = old_vel;
      top_line[c] = old_mid;
      mid_line[c] = b.conc;
      vel_line[c] = {b.vy, b.vx};
      col_in++;
      if (col_in >= n) begin
        col_in = 0;
        row_in++;
      end
      // released cell trails the sample by one row plus one cell
      if (k >= n + 1) begin
        e = k - n - 1;
        res.value = win[1];
        if (e / n != 0 && e / n != n - 1 && e % n != 0 && e % n != n - 1)
          interior_update(win[1], win[0], win[2], up_v, down_v, vel_v,
                          res.value, res.clip);
        emitted = e + 1;
        owed_cells_q.push_back(res);
      end
    end else if (row_in >= n && emitted < total) begin
      // flush of the tail: last row from mid_line, the cell before it from top
      e = emitted;
      res.value = (total - 1 - e < n) ? mid_line[e % n] : top_line[e % n];
      res.last  = (e == total - 1);
      emitted   = e + 1;
      if (res.last) begin
        row_in  = 0;
        col_in  = 0;
        emitted = 0;
      end
      owed_cells_q.push_back(res);
    end
  endfunction

  // ---- mismatch reporting and result check ---------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_result();
    cell_result_t want;
    if (owed_cells_q.size() == 0) begin
      report_mismatch("result beat with nothing owed", 32'(new_value), 0);
      return;
    end
    want = owed_cells_q.pop_front();
    if (new_value !== want.value)
      report_mismatch("new_value", 32'(new_value), 32'(want.value));
    if (frame_last !== want.last)
      report_mismatch("frame_last", 32'(frame_last), 32'(want.last));
    if (clipped !== want.clip)
      report_mismatch("clipped", 32'(clipped), 32'(want.clip));
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---- driver: one beat per handshake, random gaps and calm stretches ------
  cell_beat_t  tx_beat = '0;
  int unsigned tx_gap  = 0;
  int unsigned tx_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      push    <= 1'b0;
      tx_gap  = 0;
      tx_calm = 0;
    end else begin
      if (push && !full) begin
        predict_stencil_step(tx_beat);
        if (tx_calm > 0) begin
          tx_calm--;
          tx_gap = 0;
        end else if ($urandom_range(0, 99) == 0) begin
          tx_calm = $urandom_range(20, 80);
          tx_gap  = 0;
        end else begin
          tx_gap = idle_len();
        end
      end
      if (!push || !full) begin
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (cell_stream_q.size() > 0) begin
          tx_beat       = cell_stream_q.pop_front();
          push          <= 1'b1;
          func          <= tx_beat.func;
          concentration <= tx_beat.conc;
          vel_x         <= tx_beat.vx;
          vel_y         <= tx_beat.vy;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---- monitor: checks every popped beat, drives pop with random stalls ----
  int unsigned rx_gap    = 0;
  int unsigned rx_calm   = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      pop    <= 1'b0;
      rx_gap  = 0;
      rx_calm = 0;
    end else begin
      if (pop && !empty) begin
        check_result();
        if (rx_calm > 0) begin
          rx_calm--;
          rx_gap = 0;
        end else if ($urandom_range(0, 99) == 0) begin
          rx_calm = $urandom_range(20, 80);
          rx_gap  = 0;
        end else begin
          rx_gap = idle_len();
        end
      end
      // one long hold-off while the sender keeps pushing: fills the block
      // and forces full high
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!hold_done && cell_stream_q.size() > 100 &&
                   owed_cells_q.size() > 0) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---- watchdog: no beat anywhere for too long means a hang ----------------
  int unsigned quiet = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_wr_en) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---- register writes, only while the block is idle -----------------------
  task automatic write_register(input logic [ads_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ads_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      ads_pkg::REG_GRID_SIZE: begin
        cfg_size = data[ads_pkg::SIZE_W-1:0];
        row_in   = 0;
        col_in   = 0;
        emitted  = 0;
      end
      ads_pkg::REG_ADV_GAIN_X:  gain_ax = data[ads_pkg::AGAIN_W-1:0];
      ads_pkg::REG_ADV_GAIN_Y:  gain_ay = data[ads_pkg::AGAIN_W-1:0];
      ads_pkg::REG_DIFF_GAIN_X: gain_dx = data[ads_pkg::DGAIN_W-1:0];
      ads_pkg::REG_DIFF_GAIN_Y: gain_dy = data[ads_pkg::DGAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait until the sender is dry and every owed cell is in, then let any
  // result-free work in the back end finish
  task automatic settle();
    do @(negedge clk);
    while (cell_stream_q.size() != 0 || push || owed_cells_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [ads_pkg::CFG_DATA_W-1:0] pick_gain(input int unsigned bits);
    logic [31:0] mask;
    logic [31:0] raw;
    mask = (32'd1 << bits) - 1;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return mask[ads_pkg::CFG_DATA_W-1:0];
      2, 3, 4: return ads_pkg::CFG_DATA_W'($urandom_range(0, 4095));
      default: begin
        raw = $urandom & mask;
        return raw[ads_pkg::CFG_DATA_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [ads_pkg::CFG_IDX_W-1:0] pick_gain_reg();
    case ($urandom_range(0, 3))
      0:       return ads_pkg::REG_ADV_GAIN_X;
      1:       return ads_pkg::REG_ADV_GAIN_Y;
      2:       return ads_pkg::REG_DIFF_GAIN_X;
      default: return ads_pkg::REG_DIFF_GAIN_Y;
    endcase
  endfunction

  task automatic retune_gain(input logic [ads_pkg::CFG_IDX_W-1:0] idx);
    logic [31:0]                    spill;
    logic [ads_pkg::CFG_DATA_W-1:0] g;
    spill = $urandom;
    if (idx == ads_pkg::REG_ADV_GAIN_X || idx == ads_pkg::REG_ADV_GAIN_Y) begin
      write_register(idx, pick_gain(ads_pkg::AGAIN_W));
    end else begin
      g = pick_gain(ads_pkg::DGAIN_W);
      write_register(idx, {spill[7:0], g[15:0]});  // upper bits must be dropped
    end
  endtask

  // ---- beat makers ---------------------------------------------------------
  function automatic cell_beat_t mk_beat(input logic f, input logic [15:0] c,
                                         input logic [15:0] x, input logic [15:0] y);
    cell_beat_t b;
    b.func = f;
    b.conc = c;
    b.vx   = x;
    b.vy   = y;
    return b;
  endfunction

  function automatic logic [ads_pkg::VEL_W-1:0] edge_vel();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // mode 0: full-range noise, 1: smooth field near a base, 2: extremes
  function automatic cell_beat_t make_sample(input int mode, input logic [15:0] base);
    cell_beat_t b;
    b.func = ads_pkg::FUNC_SAMPLE;
    case (mode)
      1: begin
        b.conc = base + 16'($urandom_range(0, 1023)) - 16'd512;
        b.vx   = 16'($urandom_range(0, 2047)) - 16'd1024;
        b.vy   = 16'($urandom_range(0, 2047)) - 16'd1024;
      end
      2: begin
        case ($urandom_range(0, 3))
          0:       b.conc = 16'h0000;
          1:       b.conc = 16'hFFFF;
          2:       b.conc = 16'h4000;
          default: b.conc = 16'($urandom);
        endcase
        b.vx = edge_vel();
        b.vy = edge_vel();
      end
      default: begin
        b.conc = 16'($urandom);
        b.vx   = 16'($urandom);
        b.vy   = 16'($urandom);
      end
    endcase
    return b;
  endfunction

  function automatic cell_beat_t make_drain();
    return mk_beat(ads_pkg::FUNC_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  // One frame's worth of beats: mostly clean raster frames with random
  // content, some cut short, some pure noise.
  task automatic queue_frame(input int unsigned n);
    int unsigned kind, mode, cut, mid_at, i;
    logic [15:0] base;
    cell_beat_t  b;
    kind   = $urandom_range(0, 99);
    mode   = $urandom_range(0, 2);
    base   = 16'($urandom);
    cut    = n * n;
    mid_at = n * n + 1;
    if (kind >= 93) begin
      // noise: random func and content
      for (i = 0; i < $urandom_range(1, 8); i++) begin
        b = make_sample(0, base);
        b.func = 1'($urandom_range(0, 1));
        cell_stream_q.push_back(b);
        queued++;
      end
      return;
    end
    if (kind >= 85) cut = $urandom_range(0, n * n - 1);  // broken frame
    else if ($urandom_range(0, 4) == 0) mid_at = $urandom_range(1, n * n - 1);
    for (i = 0; i < cut; i++) begin
      if (i == mid_at) begin
        // gain change while the frame is half in
        settle();
        retune_gain(pick_gain_reg());
      end
      if ($urandom_range(0, 39) == 0) cell_stream_q.push_back(make_drain());
      cell_stream_q.push_back(make_sample(mode, base));
    end
    // tail flush; a sample here acts as a drain once the frame is in
    for (i = 0; i < n + 1; i++)
      cell_stream_q.push_back(($urandom_range(0, 3) == 0) ? make_sample(0, base)
                                                          : make_drain());
    queued += cut + n + 1;
  endtask

  // ---- stimulus ------------------------------------------------------------
  initial begin
    int unsigned i, phase, big_phases, r, n, frames;
    logic [ads_pkg::SIZE_W-1:0] size;
    logic [31:0]                spill;
    phase      = 0;
    big_phases = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // -- directed: 3x3 grid, all gains at full scale --
    write_register(ads_pkg::REG_GRID_SIZE, 24'd3);
    write_register(ads_pkg::REG_ADV_GAIN_X, 24'hFFFFFF);
    write_register(ads_pkg::REG_ADV_GAIN_Y, 24'hFFFFFF);
    write_register(ads_pkg::REG_DIFF_GAIN_X, 24'h00FFFF);
    write_register(ads_pkg::REG_DIFF_GAIN_Y, 24'h00FFFF);
    @(negedge clk);

    // drain before the frame is in: nothing comes out
    cell_stream_q.push_back(make_drain());
    // hot centre in a cold field, extreme velocities: clamps at zero
    for (i = 0; i < 9; i++)
      cell_stream_q.push_back((i == 4) ?
        mk_beat(ads_pkg::FUNC_SAMPLE, 16'hFFFF, 16'h7FFF, 16'h8000) :
        mk_beat(ads_pkg::FUNC_SAMPLE, 16'h0000, 16'h8000, 16'h7FFF));
    // tail: three drains, then a sample that only flushes (marks frame end)
    for (i = 0; i < 3; i++) cell_stream_q.push_back(make_drain());
    cell_stream_q.push_back(mk_beat(ads_pkg::FUNC_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // drain after the frame is out: nothing comes out
    cell_stream_q.push_back(make_drain());
    // cold centre in a hot field, reversed velocities: saturates high
    for (i = 0; i < 9; i++)
      cell_stream_q.push_back((i == 4) ?
        mk_beat(ads_pkg::FUNC_SAMPLE, 16'h0000, 16'h8000, 16'h7FFF) :
        mk_beat(ads_pkg::FUNC_SAMPLE, 16'hFFFF, 16'h0000, 16'hFFFF));
    for (i = 0; i < 4; i++) cell_stream_q.push_back(make_drain());

    // -- random phases; every phase starts with the block drained --
    while (queued < ITEM_TARGET) begin
      settle();
      spill = $urandom;
      r     = $urandom_range(0, 29);
      if (phase == 0) begin
        size = 9'd10;  // early busy phase so the long hold-off bites
      end else if (r == 0 && big_phases < 2) begin
        size = ($urandom_range(0, 1) == 0) ? ads_pkg::GRID_SIZE_RESET
                                           : 9'($urandom_range(257, 511));
      end else if (r <= 2) begin
        size = 9'($urandom_range(0, 2));  // below range, runs as 3
      end else begin
        size = 9'($urandom_range(3, 12));
      end
      write_register(ads_pkg::REG_GRID_SIZE, {spill[14:0], size});
      if ($urandom_range(0, 1) == 0) retune_gain(ads_pkg::REG_ADV_GAIN_X);
      if ($urandom_range(0, 1) == 0) retune_gain(ads_pkg::REG_ADV_GAIN_Y);
      if ($urandom_range(0, 1) == 0) retune_gain(ads_pkg::REG_DIFF_GAIN_X);
      if ($urandom_range(0, 1) == 0) retune_gain(ads_pkg::REG_DIFF_GAIN_Y);
      if ($urandom_range(0, 7) == 0) write_register(REG_SPARE, 24'($urandom));
      @(negedge clk);
      n = grid_n();
      if (n == ads_pkg::MAX_GRID) begin
        // large grid: one partial frame, past the first released cells
        big_phases++;
        for (i = 0; i < BIG_SAMPLES; i++) begin
          if ($urandom_range(0, 49) == 0) cell_stream_q.push_back(make_drain());
          cell_stream_q.push_back(make_sample($urandom_range(0, 2), 16'($urandom)));
        end
        queued += BIG_SAMPLES;
      end else begin
        frames = (phase == 0) ? 3 : $urandom_range(1, 3);
        for (i = 0; i < frames; i++) queue_frame(n);
      end
      phase++;
    end

    settle();
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
sv/ads_pkg.sv
sv/ads_ram.sv
sv/ads_front.sv
sv/ads_cmd_queue.sv
sv/ads_back.sv
sv/advection_diffusion_stencil_step_top.sv
sim/tb_top.sv
